// ----- sv/ccr_pkg.sv -----
// Shared types and constants for the CJK cardinal reading block.
package ccr_pkg;

    localparam int unsigned NUM_DIGITS = 16;
    localparam int unsigned POS_W      = $clog2(NUM_DIGITS);
    localparam int unsigned WORD_W     = 4 * NUM_DIGITS;

    localparam logic [1:0] KIND_DIGIT   = 2'd0;
    localparam logic [1:0] KIND_UNIT    = 2'd1;
    localparam logic [1:0] KIND_INVALID = 2'd2;

    localparam logic [3:0] UNIT_WAN = 4'd3;
    localparam logic [3:0] UNIT_YI  = 4'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DIGIT,
        S_UNIT,
        S_MARK,
        S_MARK_YI
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic       load;
        logic       latch_lo;
        logic       emit;
        logic [1:0] kind;
        logic [3:0] value;
        logic       last;
        logic       set_pending;
        logic       clr_pending;
        logic       set_emitted;
        logic       q_dec;
        logic       q_dec4;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic       invalid;
        logic       nonzero;
        logic       grp_zero;
        logic       dig_zero;
        logic [3:0] digit;
        logic [1:0] k;
        logic [1:0] g;
        logic       pending;
        logic       emitted;
        logic       is_lo;
        logic       g_is_lo;
        logic       out_free;
    } t_stat;

endpackage

// ----- sv/ccr_datapath.sv -----
// Datapath: number register, digit cursor, zero flags and output register.
module ccr_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [ccr_pkg::WORD_W-1:0]   i_bcd_digits,
    input  ccr_pkg::t_cmd                i_cmd,
    output ccr_pkg::t_stat               o_stat,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [1:0]                   o_token_kind,
    output logic [3:0]                   o_token_value,
    output logic                         o_last_token
);

    logic [ccr_pkg::WORD_W-1:0] r_word;
    logic [ccr_pkg::POS_W-1:0]  r_q;
    logic [ccr_pkg::POS_W-1:0]  r_q_lo;
    logic                       r_pending;
    logic                       r_emitted;
    logic                       r_out_valid;
    logic [1:0]                 r_kind;
    logic [3:0]                 r_value;
    logic                       r_last;

    logic                       invalid;
    logic                       nonzero;
    logic [ccr_pkg::POS_W-1:0]  lo_pos;
    logic [3:0]                 digit;
    logic [15:0]                grp_bits;

    // whole-number checks and lowest nonzero digit
    always_comb begin
        logic [3:0] nib;
        invalid = 1'b0;
        nonzero = 1'b0;
        lo_pos  = '0;
        for (int i = ccr_pkg::NUM_DIGITS - 1; i >= 0; i--) begin
            nib = r_word[4*i +: 4];
            if (nib > 4'd9) invalid = 1'b1;
            if (nib != 4'd0) begin
                nonzero = 1'b1;
                lo_pos  = ccr_pkg::POS_W'(i);
            end
        end
    end

    assign digit    = r_word[{r_q, 2'b00} +: 4];
    assign grp_bits = r_word[{r_q[ccr_pkg::POS_W-1:2], 4'b0000} +: 16];

    always_comb begin
        o_stat          = '0;
        o_stat.invalid  = invalid;
        o_stat.nonzero  = nonzero;
        o_stat.grp_zero = (grp_bits == 16'd0);
        o_stat.dig_zero = (digit == 4'd0);
        o_stat.digit    = digit;
        o_stat.k        = r_q[1:0];
        o_stat.g        = r_q[ccr_pkg::POS_W-1:2];
        o_stat.pending  = r_pending;
        o_stat.emitted  = r_emitted;
        o_stat.is_lo    = (r_q == r_q_lo);
        o_stat.g_is_lo  = (r_q[ccr_pkg::POS_W-1:2] == r_q_lo[ccr_pkg::POS_W-1:2]);
        o_stat.out_free = !r_out_valid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_word <= i_bcd_digits;
        end
        if (i_cmd.latch_lo) begin
            r_q_lo <= lo_pos;
        end
        if (i_cmd.emit) begin
            r_kind  <= i_cmd.kind;
            r_value <= i_cmd.value;
            r_last  <= i_cmd.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q         <= '1;
            r_pending   <= 1'b0;
            r_emitted   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_q       <= '1;
                r_pending <= 1'b0;
                r_emitted <= 1'b0;
            end else begin
                if (i_cmd.q_dec4) begin
                    r_q <= ccr_pkg::POS_W'(r_q - ccr_pkg::POS_W'(4));
                end else if (i_cmd.q_dec) begin
                    r_q <= ccr_pkg::POS_W'(r_q - ccr_pkg::POS_W'(1));
                end
                if (i_cmd.set_pending) begin
                    r_pending <= 1'b1;
                end else if (i_cmd.clr_pending) begin
                    r_pending <= 1'b0;
                end
                if (i_cmd.set_emitted) begin
                    r_emitted <= 1'b1;
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_token_kind  = r_kind;
    assign o_token_value = r_value;
    assign o_last_token  = r_last;

endmodule

// ----- sv/ccr_ctrl.sv -----
// Controller: walks the digits and decides which token goes out next.
module ccr_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  ccr_pkg::t_stat i_stat,
    output ccr_pkg::t_cmd  o_cmd
);

    ccr_pkg::t_state r_state;
    ccr_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ccr_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        logic drop;
        drop       = !i_stat.emitted && (i_stat.k == 2'd1) && (i_stat.digit == 4'd1);
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ccr_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ccr_pkg::S_SCAN;
                end
            end
            ccr_pkg::S_SCAN: begin
                o_cmd.latch_lo = 1'b1;
                if (i_stat.out_free) begin
                    if (i_stat.invalid) begin
                        o_cmd.emit  = 1'b1;
                        o_cmd.kind  = ccr_pkg::KIND_INVALID;
                        o_cmd.value = 4'd0;
                        o_cmd.last  = 1'b1;
                        n_state     = ccr_pkg::S_IDLE;
                    end else if (!i_stat.nonzero) begin
                        o_cmd.emit  = 1'b1;
                        o_cmd.kind  = ccr_pkg::KIND_DIGIT;
                        o_cmd.value = 4'd0;
                        o_cmd.last  = 1'b1;
                        n_state     = ccr_pkg::S_IDLE;
                    end else begin
                        n_state = ccr_pkg::S_DIGIT;
                    end
                end
            end
            ccr_pkg::S_DIGIT: begin
                if (i_stat.k == 2'd3 && i_stat.grp_zero) begin
                    // empty group: skip all four digits
                    o_cmd.set_pending = 1'b1;
                    o_cmd.q_dec4      = 1'b1;
                end else if (i_stat.dig_zero) begin
                    o_cmd.set_pending = 1'b1;
                    if (i_stat.k == 2'd0) begin
                        n_state = ccr_pkg::S_MARK;
                    end else begin
                        o_cmd.q_dec = 1'b1;
                    end
                end else if (i_stat.pending && i_stat.emitted) begin
                    if (i_stat.out_free) begin
                        o_cmd.emit        = 1'b1;
                        o_cmd.kind        = ccr_pkg::KIND_DIGIT;
                        o_cmd.value       = 4'd0;
                        o_cmd.clr_pending = 1'b1;
                    end
                end else if (drop) begin
                    // leading one in the tens place reads as plain "ten"
                    o_cmd.set_emitted = 1'b1;
                    o_cmd.clr_pending = 1'b1;
                    n_state           = ccr_pkg::S_UNIT;
                end else if (i_stat.out_free) begin
                    o_cmd.emit        = 1'b1;
                    o_cmd.kind        = ccr_pkg::KIND_DIGIT;
                    o_cmd.value       = i_stat.digit;
                    o_cmd.set_emitted = 1'b1;
                    o_cmd.clr_pending = 1'b1;
                    if (i_stat.k != 2'd0) begin
                        n_state = ccr_pkg::S_UNIT;
                    end else if (i_stat.g == 2'd0) begin
                        o_cmd.last = 1'b1;
                        n_state    = ccr_pkg::S_IDLE;
                    end else begin
                        n_state = ccr_pkg::S_MARK;
                    end
                end
            end
            ccr_pkg::S_UNIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit  = 1'b1;
                    o_cmd.kind  = ccr_pkg::KIND_UNIT;
                    o_cmd.value = {2'b00, 2'(i_stat.k - 2'd1)};
                    if (i_stat.is_lo && i_stat.g == 2'd0) begin
                        o_cmd.last = 1'b1;
                        n_state    = ccr_pkg::S_IDLE;
                    end else begin
                        o_cmd.q_dec = 1'b1;
                        n_state     = ccr_pkg::S_DIGIT;
                    end
                end
            end
            ccr_pkg::S_MARK: begin
                if (i_stat.out_free) begin
                    case (i_stat.g)
                        2'd1, 2'd2: begin
                            o_cmd.emit  = 1'b1;
                            o_cmd.kind  = ccr_pkg::KIND_UNIT;
                            o_cmd.value = (i_stat.g == 2'd1) ? ccr_pkg::UNIT_WAN
                                                             : ccr_pkg::UNIT_YI;
                            if (i_stat.g_is_lo) begin
                                o_cmd.last = 1'b1;
                                n_state    = ccr_pkg::S_IDLE;
                            end else begin
                                o_cmd.q_dec = 1'b1;
                                n_state     = ccr_pkg::S_DIGIT;
                            end
                        end
                        2'd3: begin
                            o_cmd.emit  = 1'b1;
                            o_cmd.kind  = ccr_pkg::KIND_UNIT;
                            o_cmd.value = ccr_pkg::UNIT_WAN;
                            n_state     = ccr_pkg::S_MARK_YI;
                        end
                        default: begin
                            n_state = ccr_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            ccr_pkg::S_MARK_YI: begin
                if (i_stat.out_free) begin
                    o_cmd.emit  = 1'b1;
                    o_cmd.kind  = ccr_pkg::KIND_UNIT;
                    o_cmd.value = ccr_pkg::UNIT_YI;
                    if (i_stat.g_is_lo) begin
                        o_cmd.last = 1'b1;
                        n_state    = ccr_pkg::S_IDLE;
                    end else begin
                        o_cmd.q_dec = 1'b1;
                        n_state     = ccr_pkg::S_DIGIT;
                    end
                end
            end
            default: begin
                n_state = ccr_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ----- sv/cjk_cardinal_reading_top.sv -----
// Top level of the CJK cardinal reading block: number in, reading tokens out.
//
// Input channel (i_in_valid / o_in_ready): one transfer carries a number as
// sixteen packed BCD nibbles, most significant first.
// Output channel (o_out_valid / i_out_ready): one transfer per token; kind is
// digit glyph, unit glyph or invalid, and o_last_token marks the final token.
// The number is taken in the idle state and checked in the scan state; the
// walk then emits the tokens, and also spends a step on each zero digit
// walked, each all-zero group of four skipped and a dropped leading one.
// A zero or invalid number has its single token emitted from the scan
// state, as soon as the output register is free.
// A new number is taken once the previous one's last token sits in the output
// register, so the next number's scan overlaps that token's drain.
// Reset clears the controller to idle and empties the output register.
// When the receiver stalls, the walk holds at the next token to emit until
// the output register frees up; no token is lost or repeated.
module cjk_cardinal_reading_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [ccr_pkg::WORD_W-1:0] i_bcd_digits,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [1:0]                 o_token_kind,
    output logic [3:0]                 o_token_value,
    output logic                       o_last_token
);

    ccr_pkg::t_cmd  cmd;
    ccr_pkg::t_stat stat;

    // sequencer: scan, digit walk, units and group markers
    ccr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // number register, cursor, zero flags, token output register
    ccr_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_bcd_digits  (i_bcd_digits),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_token_kind  (o_token_kind),
        .o_token_value (o_token_value),
        .o_last_token  (o_last_token)
    );

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for cjk_cardinal_reading_top: directed and random BCD numbers, tokens checked.
module tb_top;

    localparam int unsigned CLK_HALF     = 2;
    localparam int unsigned TOKEN_CAP    = 52;
    localparam int unsigned DRAIN_CYCLES = 80;
    localparam int unsigned LONG_HOLD    = 200;
    localparam int unsigned RANDOM_ITEMS = 95;
    localparam int unsigned MAX_PRINTS   = 40;
    // Worst case is about 120 numbers x 35 tokens x the longest random receiver stall; allow several times that.
    localparam longint unsigned LIMIT_CYCLES = 1_500_000;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] value;
        logic       last;
    } t_token;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_in_valid;
    logic                       o_in_ready;
    logic [ccr_pkg::WORD_W-1:0] i_bcd_digits;
    logic                       o_out_valid;
    logic                       i_out_ready;
    logic [1:0]                 o_token_kind;
    logic [3:0]                 o_token_value;
    logic                       o_last_token;

    int                         hold_count;

    cjk_cardinal_reading_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_bcd_digits  (i_bcd_digits),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_token_kind  (o_token_kind),
        .o_token_value (o_token_value),
        .o_last_token  (o_last_token)
    );

    // Holds the tokens still owed by the block, oldest first, and checks each one.
    class reading_board;
        t_token tokens_due[$];
        int     err_count;
        int     n_this;

        function new();
            err_count = 0;
            n_this    = 0;
        endfunction

        task report_mismatch(input string msg);
            if (err_count < MAX_PRINTS) begin
                $display("MISMATCH: %s", msg);
            end
            err_count++;
        endtask

        // Tokens beyond the cap are dropped
        function void add_token(input logic [1:0] kind, input logic [3:0] value);
            t_token t;
            if (n_this < TOKEN_CAP) begin
                t.kind  = kind;
                t.value = value;
                t.last  = 1'b0;
                tokens_due = {tokens_due, t};
                n_this++;
            end
        endfunction

        // Work out the reading of one accepted number and queue its tokens.
        function void read_number(input logic [ccr_pkg::WORD_W-1:0] word);
            logic [3:0] d;
            bit         any_nz;
            bit         emitted;
            bit         pending;
            t_token     t;
            any_nz  = 1'b0;
            emitted = 1'b0;
            pending = 1'b0;
            n_this  = 0;
            for (int p = 0; p < ccr_pkg::NUM_DIGITS; p++) begin
                d = word[4*p +: 4];
                if (d > 4'd9) begin
                    add_token(ccr_pkg::KIND_INVALID, 4'd0);
                    t = tokens_due[$];
                    t.last = 1'b1;
                    tokens_due[$] = t;
                    return;
                end
                if (d != 4'd0) any_nz = 1'b1;
            end
            if (!any_nz) begin
                add_token(ccr_pkg::KIND_DIGIT, 4'd0);
                t = tokens_due[$];
                t.last = 1'b1;
                tokens_due[$] = t;
                return;
            end
            for (int g = ccr_pkg::NUM_DIGITS / 4 - 1; g >= 0; g--) begin
                if (word[16*g +: 16] == 16'd0) begin
                    pending = 1'b1;
                    continue;
                end
                for (int k = 3; k >= 0; k--) begin
                    d = word[16*g + 4*k +: 4];
                    if (d == 4'd0) begin
                        pending = 1'b1;
                        continue;
                    end
                    if (pending && emitted) add_token(ccr_pkg::KIND_DIGIT, 4'd0);
                    pending = 1'b0;
                    // a leading "one ten" reads as just "ten"
                    if (!(!emitted && k == 1 && d == 4'd1)) add_token(ccr_pkg::KIND_DIGIT, d);
                    if (k > 0) add_token(ccr_pkg::KIND_UNIT, 4'(k - 1));
                    emitted = 1'b1;
                end
                case (g)
                    1: add_token(ccr_pkg::KIND_UNIT, ccr_pkg::UNIT_WAN);
                    2: add_token(ccr_pkg::KIND_UNIT, ccr_pkg::UNIT_YI);
                    3: begin
                        add_token(ccr_pkg::KIND_UNIT, ccr_pkg::UNIT_WAN);
                        add_token(ccr_pkg::KIND_UNIT, ccr_pkg::UNIT_YI);
                    end
                    default: ;
                endcase
            end
            t = tokens_due[$];
            t.last = 1'b1;
            tokens_due[$] = t;
        endfunction

        task check_token(input logic [1:0] kind, input logic [3:0] value, input logic last);
            t_token want;
            if (tokens_due.size() == 0) begin
                report_mismatch($sformatf("unexpected token kind=%0d value=%0d last=%0b",
                                          kind, value, last));
                return;
            end
            want = tokens_due.pop_front();
            if (kind !== want.kind)
                report_mismatch($sformatf("token_kind %0d, want %0d", kind, want.kind));
            if (value !== want.value)
                report_mismatch($sformatf("token_value %0d, want %0d", value, want.value));
            if (last !== want.last)
                report_mismatch($sformatf("last_token %0b, want %0b", last, want.last));
        endtask
    endclass

    reading_board board;

    always begin
        i_clk = 1'b1;
        #(CLK_HALF);
        i_clk = 1'b0;
        #(CLK_HALF);
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Zero-heavy BCD with a random length, plus raw words and single bad nibbles
    function automatic logic [ccr_pkg::WORD_W-1:0] make_number();
        logic [ccr_pkg::WORD_W-1:0] word;
        int                         len;
        int                         r;
        word = '0;
        r    = $urandom_range(0, 99);
        if (r < 10) begin
            word = {$urandom, $urandom};
        end else begin
            len = $urandom_range(1, ccr_pkg::NUM_DIGITS);
            for (int p = 0; p < len; p++) begin
                if ($urandom_range(0, 99) < 40) word[4*p +: 4] = 4'd0;
                else word[4*p +: 4] = 4'($urandom_range(1, 9));
            end
            // blank out a whole group now and then
            if ($urandom_range(0, 3) == 0)
                word[16*$urandom_range(0, 3) +: 16] = 16'd0;
            if (r >= 95)
                word[4*$urandom_range(0, ccr_pkg::NUM_DIGITS - 1) +: 4] =
                    4'($urandom_range(10, 15));
        end
        return word;
    endfunction

    // Leaves valid high; the caller lowers it only when a gap follows.
    task automatic send_number(input logic [ccr_pkg::WORD_W-1:0] word);
        i_in_valid   <= 1'b1;
        i_bcd_digits <= word;
        do @(posedge i_clk); while (!o_in_ready);
        board.read_number(word);
    endtask

    task automatic sender_idle(input int cycles);
        if (cycles > 0) begin
            i_in_valid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        while (board.tokens_due.size() != 0) @(posedge i_clk);
    endtask

    // Receiver: checks every transfer, stalls at random, and honors a long hold request.
    initial begin
        int idle_left;
        int busy_left;
        int holds_done;
        idle_left  = 0;
        busy_left  = 0;
        holds_done = 0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready)
                board.check_token(o_token_kind, o_token_value, o_last_token);
            if (hold_count != holds_done) begin
                holds_done = hold_count;
                idle_left  = LONG_HOLD;
                busy_left  = 0;
            end
            if (idle_left > 0) begin
                i_out_ready <= 1'b0;
                idle_left--;
            end else begin
                i_out_ready <= 1'b1;
                if (busy_left > 0) begin
                    busy_left--;
                end else begin
                    busy_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                            : $urandom_range(0, 12);
                    idle_left = pick_gap();
                end
            end
        end
    end

    initial begin
        logic [ccr_pkg::WORD_W-1:0] directed_words[$];
        board        = new();
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_bcd_digits = '0;
        i_out_ready  = 1'b0;
        hold_count   = 0;

        directed_words = '{
            64'h0000_0000_0000_0000,    // zero reads as a lone zero glyph
            64'h0000_0000_0000_0001,
            64'h0000_0000_0000_0009,
            64'h0000_0000_0000_0010,    // leading one ten dropped
            64'h0000_0000_0000_0011,
            64'h0000_0000_0000_0019,
            64'h0000_0000_0000_0020,
            64'h0000_0000_0000_0114,    // one ten kept after a hundred
            64'h0000_0000_0000_0100,
            64'h0000_0000_0000_1001,    // inner zeros collapse to one glyph
            64'h0000_0000_0001_0000,
            64'h0000_0000_0001_0010,
            64'h0000_0001_0000_0000,
            64'h0001_0000_0000_0000,
            64'h9999_9999_9999_9999,
            64'h1000_0000_0000_0000,
            64'h0010_0000_0000_0000,    // dropped one ten in the top group
            64'h0000_0001_0000_0001,    // all-zero group between two digits
            64'h1010_1010_1010_1010,
            64'h1111_1111_1111_1111,
            64'h0000_5000_0000_0007,
            64'h0000_0000_0000_000A,    // bad nibble at the bottom
            64'hF000_0000_0000_0000,    // bad nibble at the top
            64'h0000_0000_000B_0000,
            64'hFFFF_FFFF_FFFF_FFFF
        };

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_words[i]) begin
            send_number(directed_words[i]);
            sender_idle(pick_gap());
        end
        sender_idle(1);
        wait_drained();

        for (int i = 0; i < RANDOM_ITEMS / 2; i++) begin
            send_number(make_number());
            sender_idle(pick_gap());
        end

        // Receiver holds off while numbers keep coming back to back
        hold_count++;
        for (int i = 0; i < 15; i++) send_number(make_number());

        // Sender waits for every owed token before going on
        sender_idle(1);
        wait_drained();

        for (int i = 0; i < RANDOM_ITEMS / 2 - 15; i++) begin
            send_number(make_number());
            sender_idle(pick_gap());
        end
        sender_idle(1);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.tokens_due.size() != 0)
            board.report_mismatch($sformatf("%0d tokens never arrived",
                                            board.tokens_due.size()));

        if (board.err_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #(LIMIT_CYCLES * 2 * CLK_HALF);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
